@@ hdl/cidse_pkg.sv @@
// ----------------------------------------------------------------------------
// cidse_pkg
// Shared types and constants of the CAN id self-enumeration block.
// ----------------------------------------------------------------------------
package cidse_pkg;

	// Field widths.
	localparam int ID_W    = 7;
	localparam int NN_W    = 16;
	localparam int TICK_W  = 8;
	localparam int LEN_W   = 4;
	localparam int PRI_W   = 4;
	localparam int FUNC_W  = 2;
	localparam int CFG_A_W = 2;

	// The used-id map is kept as rows of eight ids.
	localparam int ROW_BITS = 8;
	localparam int COL_W    = 3;
	localparam int ROW_W    = ID_W - COL_W;
	localparam int ROWS     = 1 << ROW_W;

	// Input function codes.
	localparam logic [FUNC_W-1:0] FN_START = 2'd0;
	localparam logic [FUNC_W-1:0] FN_RESP  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_A_W-1:0] CFG_NODE_CAN_ID  = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_NODE_NUMBER  = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_WINDOW_TICKS = 2'd2;

	// Frame constants.
	localparam logic [ID_W-1:0]   RTR_CAN_ID      = 7'h7F;
	localparam logic [PRI_W-1:0]  DATA_PRI        = 4'd11;
	localparam logic [TICK_W-1:0] WINDOW_RESET    = 8'd10;
	localparam logic [LEN_W-1:0]  LEN_RTR         = 4'd0;
	localparam logic [LEN_W-1:0]  LEN_ACK         = 4'd3;
	localparam logic [LEN_W-1:0]  LEN_ERR         = 4'd4;
	localparam logic [LEN_W-1:0]  LEN_NNREQ       = 4'd3;

	typedef enum logic [1:0] {
		FK_REMOTE = 2'd0,
		FK_ACK    = 2'd1,
		FK_ERR    = 2'd2,
		FK_NNREQ  = 2'd3
	} frame_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FRAME0,
		ST_FRAME1
	} state_t;

	// Commands from the sequencer to the id map.
	typedef struct packed {
		logic clear;
		logic mark;
		logic start;
	} map_ctrl_t;

	// Result of one scan for a free id.
	typedef struct packed {
		logic            done;
		logic            found;
		logic [ID_W-1:0] id;
	} scan_res_t;

endpackage

@@ hdl/cidse_idmap.sv @@
// ----------------------------------------------------------------------------
// cidse_idmap
// Map of CAN ids seen in responses, with a row-serial search for the
// lowest free id from 1 to MAX_ID-1.
// ----------------------------------------------------------------------------
module cidse_idmap #(
	parameter int MAX_ID = 100
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cidse_pkg::map_ctrl_t       ctrl,
	input  logic [cidse_pkg::ID_W-1:0] mark_id,
	output cidse_pkg::scan_res_t       res
);
	import cidse_pkg::*;

	localparam int LAST_ROW = (MAX_ID - 1) / ROW_BITS;

	logic [ROWS-1:0][ROW_BITS-1:0] used_q;
	logic [ROW_W-1:0]              row_q;
	logic                          busy_q;
	scan_res_t                     res_q;

	logic [ROW_BITS-1:0] row_bits;
	logic [ROW_BITS-1:0] elig;
	logic [ID_W-1:0]     cand_id;
	logic                hit;
	logic [COL_W-1:0]    hit_col;
	logic                at_last;

	// Free ids of the row under the scan pointer, lowest one wins.
	always_comb begin
		row_bits = used_q[row_q];
		hit      = 1'b0;
		hit_col  = '0;
		for (int b = 0; b < ROW_BITS; b++) begin
			cand_id = {row_q, COL_W'(b)};
			elig[b] = !row_bits[b] && (cand_id != '0)
				&& ({1'b0, cand_id} < (ID_W+1)'(MAX_ID));
		end
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (elig[b]) begin
				hit     = 1'b1;
				hit_col = COL_W'(b);
			end
		end
		at_last = (row_q == ROW_W'(LAST_ROW));
	end

	// Used-id bits: cleared by reset and at the start of a window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctrl.clear) begin
			used_q <= '0;
		end else if (ctrl.mark) begin
			used_q[mark_id[ID_W-1:COL_W]][mark_id[COL_W-1:0]] <= 1'b1;
		end
	end

	// Scan sequencer: one row of eight ids per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			res_q  <= '0;
		end else begin
			res_q.done <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (busy_q) begin
				if (hit || at_last) begin
					busy_q      <= 1'b0;
					res_q.done  <= 1'b1;
					res_q.found <= hit;
					res_q.id    <= hit ? {row_q, hit_col} : '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

	assign res = res_q;

`ifndef SYNTHESIS
	// A found id lies inside the searched range.
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done && res_q.found |-> (res_q.id != '0)
			&& ({1'b0, res_q.id} < (ID_W+1)'(MAX_ID)))
		else $error("scan returned an id outside the range");

	// The pointer never walks past the last row of the range.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (row_q <= ROW_W'(LAST_ROW)))
		else $error("scan pointer ran past the last row");

	// A scan reports exactly once, on the cycle after it stops.
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !ctrl.start && (hit || at_last) |=> res_q.done && !busy_q)
		else $error("scan ended without a result");
`endif

endmodule

@@ hdl/can_id_self_enumeration_top.sv @@
// ----------------------------------------------------------------------------
// can_id_self_enumeration_top
// CAN node id self-enumeration: collects response ids during a window of
// timer ticks and picks the lowest free id when the window closes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry func (start, response, tick) and resp_can_id. A beat
//   is taken when in_valid is high and in_stall is low. Response beats and
//   ticks that do not close the window leave in_stall low. A start beat
//   clears the id map, loads the window and queues the remote request frame.
//   The tick that closes the window starts a search of the id map, one row
//   of eight ids per cycle, that stops at the first row that holds a free id
//   or at the last row of the range; the registered result then moves the
//   sequencer to the first of its two frames.
//   in_stall stays high from such a start or closing tick until its frames
//   have entered the output register.
//   Output beats leave a single output register; a frame is held while
//   out_stall is high, and the next frame is loaded in the cycle it is taken.
//   Configuration writes are always ready and take effect the next cycle.
//   Reset clears the map and the countdown, node_can_id and node_number to
//   zero and window_ticks to ten; no output beat is pending after reset.
// ----------------------------------------------------------------------------
module can_id_self_enumeration_top #(
	parameter int MAX_ID = 100
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cidse_pkg::CFG_A_W-1:0] cfg_index,
	input  logic [cidse_pkg::NN_W-1:0]    cfg_data,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cidse_pkg::FUNC_W-1:0]  func,
	input  logic [cidse_pkg::ID_W-1:0]    resp_can_id,
	// Output channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    frame_kind,
	output logic [cidse_pkg::ID_W-1:0]    frame_can_id,
	output logic [cidse_pkg::PRI_W-1:0]   frame_priority,
	output logic                          is_remote,
	output logic [cidse_pkg::LEN_W-1:0]   frame_length,
	output logic [cidse_pkg::NN_W-1:0]    frame_node_number,
	output logic                          id_assigned,
	output logic [cidse_pkg::ID_W-1:0]    new_can_id,
	output logic                          last
);
	import cidse_pkg::*;

	state_t            state_q, state_nx;
	logic [ID_W-1:0]   node_can_id_q;
	logic [NN_W-1:0]   node_number_q;
	logic [TICK_W-1:0] window_ticks_q;
	logic [TICK_W-1:0] countdown_q;
	frame_kind_t       kind0_q;
	logic              assigned_q;
	logic [ID_W-1:0]   newid_q;

	logic              out_valid_q;
	frame_kind_t       frame_kind_q;
	logic [ID_W-1:0]   frame_can_id_q;
	logic              is_remote_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [NN_W-1:0]   frame_node_number_q;
	logic              id_assigned_q;
	logic [ID_W-1:0]   new_can_id_q;
	logic              last_q;

	logic              in_acc;
	logic              slot_free;
	logic              window_close;
	logic              load_out;
	map_ctrl_t         map_ctrl;
	scan_res_t         scan_res;

	frame_kind_t       f_kind;
	logic [ID_W-1:0]   f_can_id;
	logic              f_remote;
	logic [LEN_W-1:0]  f_len;
	logic [NN_W-1:0]   f_nn;
	logic              f_assigned;
	logic [ID_W-1:0]   f_newid;
	logic              f_last;

	cidse_idmap #(
		.MAX_ID (MAX_ID)
	) u_idmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (map_ctrl),
		.mark_id (resp_can_id),
		.res     (scan_res)
	);

	assign in_acc       = in_valid && !in_stall;
	assign slot_free    = !out_valid_q || !out_stall;
	assign window_close = (func == FN_TICK) && (countdown_q == TICK_W'(1));

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && func == FN_START) begin
					state_nx = ST_FRAME0;
				end else if (in_acc && window_close) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_res.done) begin
					state_nx = ST_FRAME0;
				end
			end
			ST_FRAME0: begin
				if (slot_free) begin
					state_nx = (kind0_q == FK_REMOTE) ? ST_IDLE : ST_FRAME1;
				end
			end
			ST_FRAME1: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		map_ctrl.clear = in_acc && (func == FN_START);
		map_ctrl.mark  = in_acc && (func == FN_RESP) && (countdown_q != '0);
		map_ctrl.start = in_acc && window_close;
		load_out       = slot_free && (state_q == ST_FRAME0 || state_q == ST_FRAME1);
		f_kind         = (state_q == ST_FRAME1) ? FK_NNREQ : kind0_q;
	end

	// Frame fields by kind.
	always_comb begin
		f_can_id   = node_can_id_q;
		f_remote   = 1'b0;
		f_nn       = node_number_q;
		f_assigned = assigned_q;
		f_newid    = newid_q;
		f_last     = 1'b0;
		case (f_kind)
			FK_REMOTE: begin
				f_can_id   = RTR_CAN_ID;
				f_remote   = 1'b1;
				f_len      = LEN_RTR;
				f_nn       = '0;
				f_assigned = 1'b0;
				f_newid    = '0;
				f_last     = 1'b1;
			end
			FK_ACK:   f_len = LEN_ACK;
			FK_ERR:   f_len = LEN_ERR;
			FK_NNREQ: begin
				f_len  = LEN_NNREQ;
				f_last = 1'b1;
			end
			default:  f_len = LEN_RTR;
		endcase
	end

	// Control state, registers and countdown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			node_can_id_q  <= '0;
			node_number_q  <= '0;
			window_ticks_q <= WINDOW_RESET;
			countdown_q    <= '0;
			kind0_q        <= FK_REMOTE;
			assigned_q     <= 1'b0;
			newid_q        <= '0;
		end else begin
			state_q <= state_nx;
			if (in_acc && func == FN_START) begin
				countdown_q <= window_ticks_q;
				kind0_q     <= FK_REMOTE;
			end else if (in_acc && func == FN_TICK && countdown_q != '0) begin
				countdown_q <= countdown_q - TICK_W'(1);
			end
			if (state_q == ST_SCAN && scan_res.done) begin
				kind0_q    <= scan_res.found ? FK_ACK : FK_ERR;
				assigned_q <= scan_res.found;
				newid_q    <= scan_res.id;
				if (scan_res.found) begin
					node_can_id_q <= scan_res.id;
				end
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_NODE_CAN_ID:  node_can_id_q  <= cfg_data[ID_W-1:0];
					CFG_NODE_NUMBER:  node_number_q  <= cfg_data;
					CFG_WINDOW_TICKS: window_ticks_q <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			frame_kind_q        <= f_kind;
			frame_can_id_q      <= f_can_id;
			is_remote_q         <= f_remote;
			frame_length_q      <= f_len;
			frame_node_number_q <= f_nn;
			id_assigned_q       <= f_assigned;
			new_can_id_q        <= f_newid;
			last_q              <= f_last;
		end
	end

	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign frame_kind        = frame_kind_q;
	assign frame_can_id      = frame_can_id_q;
	assign frame_priority    = DATA_PRI;
	assign is_remote         = is_remote_q;
	assign frame_length      = frame_length_q;
	assign frame_node_number = frame_node_number_q;
	assign id_assigned       = id_assigned_q;
	assign new_can_id        = new_can_id_q;
	assign last              = last_q;

`ifndef SYNTHESIS
	// A scan result is only produced while the sequencer waits for it.
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> state_q == ST_SCAN)
		else $error("scan result outside the scan state");

	// The second frame only follows an acknowledge or an error frame.
	a_second_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRAME1 |-> kind0_q == FK_ACK || kind0_q == FK_ERR)
		else $error("second frame after a remote request");

	// An acknowledge carries the id just stored as the node id.
	a_ack_id: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRAME0 && kind0_q == FK_ACK |-> node_can_id_q == newid_q)
		else $error("acknowledge id differs from the stored node id");

	// The window is closed while the map is searched.
	a_scan_idle_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> countdown_q == '0)
		else $error("search running with the window open");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CAN id self-enumeration block against a cycle-free predictor of
// its id map, window countdown and frame contents. Directed tests cover the
// idle cases, restarts and window extremes. Random phases then run complete
// enumerations with random content, dense map fills and noise, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import cidse_pkg::*;

	localparam int MAX_ID        = 100;
	localparam int ITEM_TARGET   = 1200;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 400;
	localparam int QUIET_LIMIT   = 2000;

	// Function code that the block does not define; such beats are dropped.
	localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

	// One expected output frame.
	typedef struct {
		frame_kind_t      kind;
		logic [ID_W-1:0]  can_id;
		logic [PRI_W-1:0] pri;
		logic             remote;
		logic [LEN_W-1:0] length;
		logic [NN_W-1:0]  node_nr;
		logic             assigned;
		logic [ID_W-1:0]  new_id;
		logic             last_beat;
	} frame_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_valid   = 1'b0;
	logic               cfg_ready;
	logic [CFG_A_W-1:0] cfg_index   = CFG_NODE_CAN_ID;
	logic [NN_W-1:0]    cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [FUNC_W-1:0]  func        = FN_TICK;
	logic [ID_W-1:0]    resp_can_id = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [1:0]         frame_kind;
	logic [ID_W-1:0]    frame_can_id;
	logic [PRI_W-1:0]   frame_priority;
	logic               is_remote;
	logic [LEN_W-1:0]   frame_length;
	logic [NN_W-1:0]    frame_node_number;
	logic               id_assigned;
	logic [ID_W-1:0]    new_can_id;
	logic               last;

	// Predicted state of the block and its registers.
	logic [127:0]      used_ids;
	logic [TICK_W-1:0] ticks_left;
	logic [ID_W-1:0]   node_id_reg;
	logic [NN_W-1:0]   node_nr_reg;
	logic [TICK_W-1:0] window_reg;
	frame_t            frames_due[$];

	int items_taken   = 0;
	int errors        = 0;
	int hold_requests = 0;
	bit steady_send   = 1'b0;

	can_id_self_enumeration_top #(.MAX_ID(MAX_ID)) dut (.*);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic frame_t make_frame(input frame_kind_t kind, input logic [ID_W-1:0] can_id,
			input logic remote, input logic [LEN_W-1:0] length, input logic [NN_W-1:0] node_nr,
			input logic assigned, input logic [ID_W-1:0] new_id, input logic last_beat);
		frame_t f;
		f.kind      = kind;
		f.can_id    = can_id;
		f.pri       = DATA_PRI;
		f.remote    = remote;
		f.length    = length;
		f.node_nr   = node_nr;
		f.assigned  = assigned;
		f.new_id    = new_id;
		f.last_beat = last_beat;
		return f;
	endfunction

	// Applies one accepted input beat to the predicted state and queues the
	// frames it causes. Returns 1 when the beat was not simply dropped.
	function automatic bit enumerate_step(input logic [FUNC_W-1:0] fn,
			input logic [ID_W-1:0] rid);
		bit taken;
		bit found;
		int id;
		taken = 1'b0;
		found = 1'b0;
		id    = 0;
		case (fn)
		FN_START: begin
			used_ids   = '0;
			ticks_left = window_reg;
			frames_due.push_back(make_frame(FK_REMOTE, RTR_CAN_ID, 1'b1, LEN_RTR, '0, 1'b0, '0,
				1'b1));
			taken = 1'b1;
		end
		FN_RESP: begin
			if (ticks_left != 0) begin
				used_ids[rid] = 1'b1;
				taken = 1'b1;
			end
		end
		FN_TICK: begin
			if (ticks_left != 0) begin
				taken = 1'b1;
				ticks_left = ticks_left - TICK_W'(1);
				if (ticks_left == 0) begin
					// The window closed: take the lowest free id above zero.
					for (int i = 1; i < MAX_ID && i < 128; i++) begin
						if (!found && !used_ids[i]) begin
							found = 1'b1;
							id = i;
						end
					end
					if (found) begin
						node_id_reg = id[ID_W-1:0];
						frames_due.push_back(make_frame(FK_ACK, node_id_reg, 1'b0, LEN_ACK,
							node_nr_reg, 1'b1, id[ID_W-1:0], 1'b0));
						frames_due.push_back(make_frame(FK_NNREQ, node_id_reg, 1'b0, LEN_NNREQ,
							node_nr_reg, 1'b1, id[ID_W-1:0], 1'b1));
					end else begin
						frames_due.push_back(make_frame(FK_ERR, node_id_reg, 1'b0, LEN_ERR,
							node_nr_reg, 1'b0, '0, 1'b0));
						frames_due.push_back(make_frame(FK_NNREQ, node_id_reg, 1'b0, LEN_NNREQ,
							node_nr_reg, 1'b0, '0, 1'b1));
					end
				end
			end
		end
		default: begin
			taken = 1'b0;
		end
		endcase
		return taken;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [NN_W-1:0] got,
			input logic [NN_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Gap after an input beat: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_send || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Response ids lean toward the bottom of the search range and its top edge.
	function automatic logic [ID_W-1:0] rand_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return ID_W'($urandom_range(0, 12));
		end
		if (r < 7) begin
			return ID_W'($urandom_range(MAX_ID - 3, MAX_ID + 1));
		end
		return ID_W'($urandom_range(0, 127));
	endfunction

	// Offers one input beat, waits until it is taken, then idles for a random gap.
	task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] rid);
		int gap;
		in_valid    <= 1'b1;
		func        <= fn;
		resp_can_id <= rid;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (enumerate_step(fn, rid)) begin
			items_taken++;
		end
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every expected frame has come and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; cfg_valid is left high for a following write.
	task automatic write_register(input logic [CFG_A_W-1:0] idx, input logic [NN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
		CFG_NODE_CAN_ID:  node_id_reg = data[ID_W-1:0];
		CFG_NODE_NUMBER:  node_nr_reg = data;
		CFG_WINDOW_TICKS: window_reg = data[TICK_W-1:0];
		default:          ;
		endcase
	endtask

	task automatic configure(input logic [ID_W-1:0] node_id, input logic [NN_W-1:0] node_nr,
			input logic [TICK_W-1:0] window);
		settle();
		write_register(CFG_NODE_CAN_ID, NN_W'(node_id));
		write_register(CFG_NODE_NUMBER, node_nr);
		write_register(CFG_WINDOW_TICKS, NN_W'(window));
		cfg_valid <= 1'b0;
	endtask

	// Ticks until the open window closes.
	task automatic close_window();
		while (ticks_left != 0) begin
			send_item(FN_TICK, rand_id());
		end
	endtask

	// Marks every searchable id except the hole (zero leaves none) in random
	// order, with stray ticks while the window still has room.
	task automatic fill_map_sequence(input int hole);
		int pool[$];
		int j;
		int tmp;
		for (int i = 1; i < MAX_ID; i++) begin
			if (i != hole) begin
				pool.push_back(i);
			end
		end
		for (int i = pool.size() - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			tmp     = pool[i];
			pool[i] = pool[j];
			pool[j] = tmp;
		end
		send_item(FN_START, rand_id());
		foreach (pool[k]) begin
			if (ticks_left > 1 && $urandom_range(0, 19) == 0) begin
				send_item(FN_TICK, rand_id());
			end
			send_item(FN_RESP, ID_W'(pool[k]));
		end
		close_window();
	endtask

	// A full enumeration with sparse responses, rare restarts and stray codes.
	task automatic sparse_sequence();
		int r;
		send_item(FN_START, rand_id());
		while (ticks_left != 0) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_item(FN_TICK, rand_id());
			end else if (r < 97) begin
				send_item(FN_RESP, rand_id());
			end else if (r < 98) begin
				send_item(FN_START, rand_id());
			end else begin
				send_item(FN_NONE, rand_id());
			end
		end
	endtask

	// Beats with any code and any id, in or out of a window.
	task automatic noise_burst();
		repeat ($urandom_range(1, 6)) begin
			send_item(FUNC_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 127)));
		end
	endtask

	// Responses, ticks and an undefined code are all dropped while idle.
	task automatic test_idle_items();
		send_item(FN_RESP, 7'h55);
		send_item(FN_TICK, 7'h2A);
		send_item(FN_NONE, 7'h7F);
	endtask

	// Reset register values: window of ten ticks, node number zero. Ids zero
	// and 127 lie outside the search, so the lowest free id is three.
	task automatic test_default_window();
		send_item(FN_START, 7'h00);
		send_item(FN_RESP, 7'd1);
		send_item(FN_RESP, 7'd2);
		send_item(FN_RESP, 7'h7F);
		send_item(FN_RESP, 7'd0);
		close_window();
	endtask

	// A start during the window clears the map and sends the request again.
	task automatic test_restart();
		configure(7'h15, 16'h1234, 8'd2);
		send_item(FN_START, 7'h33);
		send_item(FN_RESP, 7'd1);
		send_item(FN_START, 7'h4C);
		send_item(FN_NONE, 7'd1);
		send_item(FN_RESP, 7'd2);
		close_window();
	endtask

	// A window of zero ticks sends the request and leaves the block idle.
	task automatic test_zero_window();
		configure(7'h2B, 16'hA5A5, 8'd0);
		send_item(FN_START, 7'h7F);
		send_item(FN_TICK, 7'h00);
		send_item(FN_RESP, 7'd9);
	endtask

	// Longest window, full map, and a map with only the top id free.
	task automatic test_config_extremes();
		configure(7'h7F, 16'hFFFF, 8'd255);
		send_item(FN_START, 7'h00);
		send_item(FN_RESP, 7'd1);
		close_window();
		configure(7'h00, 16'h0000, 8'd1);
		fill_map_sequence(0);
		configure(7'h7F, 16'hFFFF, 8'd1);
		fill_map_sequence(MAX_ID - 1);
	endtask

	// The receiver holds off while beats keep coming, so the block fills up
	// and stalls its input.
	task automatic test_back_pressure();
		configure(rand_id(), 16'($urandom_range(0, 65535)), 8'd2);
		steady_send = 1'b1;
		hold_requests++;
		repeat (4) begin
			send_item(FN_START, rand_id());
			send_item(FN_TICK, rand_id());
			send_item(FN_TICK, rand_id());
		end
		steady_send = 1'b0;
		settle();
	endtask

	// Random phases, each with its own register settings.
	task automatic test_random_enumeration();
		int phase_end;
		int r;
		int hole;
		logic [TICK_W-1:0] window;
		logic [NN_W-1:0] node_nr;
		while (items_taken < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				window = 8'd1;
			end else if (r < 90) begin
				window = TICK_W'($urandom_range(2, 8));
			end else begin
				window = TICK_W'($urandom_range(9, 40));
			end
			r = $urandom_range(0, 3);
			if (r == 0) begin
				node_nr = 16'h0000;
			end else if (r == 1) begin
				node_nr = 16'hFFFF;
			end else begin
				node_nr = 16'($urandom_range(0, 65535));
			end
			configure(ID_W'($urandom_range(0, 127)), node_nr, window);
			phase_end = items_taken + $urandom_range(80, 160);
			while (items_taken < phase_end) begin
				steady_send = ($urandom_range(0, 4) == 0);
				r = $urandom_range(0, 99);
				if (r < 12) begin
					case ($urandom_range(0, 3))
					0:       hole = 0;
					1:       hole = MAX_ID - 1;
					2:       hole = 1;
					default: hole = $urandom_range(1, MAX_ID - 1);
					endcase
					fill_map_sequence(hole);
				end else if (r < 85) begin
					sparse_sequence();
				end else begin
					noise_burst();
				end
			end
			steady_send = 1'b0;
			close_window();
		end
	endtask

	// Compares each output beat with the oldest expected frame.
	always @(posedge clk) begin
		frame_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				report_mismatch($sformatf("frame of kind %0d with none expected", frame_kind));
			end else begin
				due = frames_due.pop_front();
				check_field("frame_kind", NN_W'(frame_kind), NN_W'(due.kind));
				check_field("frame_can_id", NN_W'(frame_can_id), NN_W'(due.can_id));
				check_field("frame_priority", NN_W'(frame_priority), NN_W'(due.pri));
				check_field("is_remote", NN_W'(is_remote), NN_W'(due.remote));
				check_field("frame_length", NN_W'(frame_length), NN_W'(due.length));
				check_field("frame_node_number", frame_node_number, due.node_nr);
				check_field("id_assigned", NN_W'(id_assigned), NN_W'(due.assigned));
				check_field("new_can_id", NN_W'(new_can_id), NN_W'(due.new_id));
				check_field("last", NN_W'(last), NN_W'(due.last_beat));
			end
		end
	end

	// Output stalls: calm stretches alternate with random stalls, and each
	// hold request blocks the output for a long run of cycles.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		int stretch_left;
		int stall_left;
		int r;
		bit calm;
		hold_left    = 0;
		hold_seen    = 0;
		stretch_left = 0;
		stall_left   = 0;
		calm         = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (stretch_left == 0) begin
				calm         = ($urandom_range(0, 3) == 0);
				stretch_left = $urandom_range(20, 200);
			end
			stretch_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (!calm && r >= 60) begin
					stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(7, 39);
				end
				out_stall <= (!calm && r >= 60);
			end
		end
	end

	// Ends the run when no beat moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

	// Test sequence.
	initial begin
		used_ids    = '0;
		ticks_left  = '0;
		node_id_reg = '0;
		node_nr_reg = '0;
		window_reg  = WINDOW_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_items();
		test_default_window();
		test_restart();
		test_zero_window();
		test_config_extremes();
		test_back_pressure();
		test_random_enumeration();
		settle();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
